@@ hw/rtl/histogram_percentile_bounds_core_macros.svh @@
// Assertion macros for the histogram percentile bounds core.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef HISTOGRAM_PERCENTILE_BOUNDS_CORE_MACROS_SVH
`define HISTOGRAM_PERCENTILE_BOUNDS_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define HPB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpb assertion failed");
`define HPB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpb assertion failed");
`else
`define HPB_ASSERT_IMP(label, ante, cons)
`define HPB_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/hpb_pkg.sv @@
package hpb_pkg;

    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int COUNT_W         = MAX_PIXELS_LOG2 + 1;
    localparam int BIN_W           = 8;
    localparam int BINS            = 256;
    localparam int NUM_CH          = 3;
    localparam int FRAC_W          = 17;
    localparam int FRAC_SHIFT      = 16;
    localparam int PROD_W          = COUNT_W + FRAC_W;
    localparam int THR_W           = PROD_W + 1 - FRAC_SHIFT;
    localparam int SUM_W           = COUNT_W + BIN_W;
    localparam int CMP_W           = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int CFG_IDX_W       = 2;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [PROD_W:0]    ROUND_HALF  = (PROD_W + 1)'(1) << (FRAC_SHIFT - 1);
    localparam logic [BIN_W-1:0]   BIN_LAST    = BIN_W'(BINS - 1);
    localparam logic [BIN_W-1:0]   BOUND_NONE  = BIN_W'(BINS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_FRACTION = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_FRACTION = CFG_IDX_W'(2);

    localparam logic [FRAC_W-1:0] LOWER_FRACTION_RST = FRAC_W'(655);
    localparam logic [FRAC_W-1:0] UPPER_FRACTION_RST = FRAC_W'(64881);

    localparam logic ACTION_END = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_MULT,
        ST_ROUND,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } hpb_state_t;

endpackage

@@ hw/rtl/hpb_ram.sv @@
module hpb_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/hpb_scan.sv @@
module hpb_scan import hpb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               valid,
    input  logic [BIN_W-1:0]   idx,
    input  logic [COUNT_W-1:0] count,
    input  logic [THR_W-1:0]   lo_thr,
    input  logic [THR_W-1:0]   hi_thr,
    output logic [BIN_W-1:0]   lo_bound,
    output logic [BIN_W-1:0]   hi_bound
);

    logic [SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic             lo_found_reg, lo_found_next;
    logic             hi_found_reg, hi_found_next;
    logic [BIN_W-1:0] lo_reg, lo_next;
    logic [BIN_W-1:0] hi_reg, hi_next;

    assign sum_add = sum_reg + SUM_W'(count);

    always_comb
    begin
        sum_next      = sum_reg;
        lo_found_next = lo_found_reg;
        hi_found_next = hi_found_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        if (start)
        begin
            sum_next      = '0;
            lo_found_next = 1'b0;
            hi_found_next = 1'b0;
            lo_next       = BOUND_NONE;
            hi_next       = BOUND_NONE;
        end
        else if (valid)
        begin
            sum_next = sum_add;
            if (!lo_found_reg)
            begin
                if (CMP_W'(sum_add) > CMP_W'(lo_thr))
                begin
                    lo_found_next = 1'b1;
                    lo_next       = idx;
                end
            end
            else if (!hi_found_reg)
            begin
                // high search starts at the bin after the low bound
                if (CMP_W'(sum_add) > CMP_W'(hi_thr))
                begin
                    hi_found_next = 1'b1;
                    hi_next       = idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
            lo_reg       <= BOUND_NONE;
            hi_reg       <= BOUND_NONE;
        end
        else
        begin
            sum_reg      <= sum_next;
            lo_found_reg <= lo_found_next;
            hi_found_reg <= hi_found_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
        end
    end

    assign lo_bound = lo_reg;
    assign hi_bound = hi_reg;

endmodule

@@ hw/rtl/histogram_percentile_bounds_core.sv @@
// Pixels: one item per cycle while in ST_RUN, read-modify-write of the bin RAMs forwarding
// the previous cycle's write. End of image: after the item is taken the core multiplies,
// rounds, scans the 256 bins of the RAMs and drains, and no input is taken until the
// result is loaded. The scan walks one bin per cycle through the RAM read port and zeroes
// each bin. Reset: config registers to defaults, then a pass over all 256 bins zeroes the
// bin RAMs with ready low; configuration writes are taken throughout.
`include "histogram_percentile_bounds_core_macros.svh"

module histogram_percentile_bounds_core import hpb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [BIN_W-1:0]     red_value,
    input  logic [BIN_W-1:0]     green_value,
    input  logic [BIN_W-1:0]     blue_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BIN_W-1:0]     red_low_bound,
    output logic [BIN_W-1:0]     red_high_bound,
    output logic [BIN_W-1:0]     green_low_bound,
    output logic [BIN_W-1:0]     green_high_bound,
    output logic [BIN_W-1:0]     blue_low_bound,
    output logic [BIN_W-1:0]     blue_high_bound,
    output logic [COUNT_W-1:0]   peak_bin_count,
    output logic [COUNT_W-1:0]   total_pixels
);

    hpb_state_t         st_reg, st_next;
    logic [BIN_W-1:0]   cnt_reg, cnt_next;

    logic               gray_mode_reg;
    logic [FRAC_W-1:0]  lower_frac_reg;
    logic [FRAC_W-1:0]  upper_frac_reg;

    logic               s1_valid_reg;
    logic [NUM_CH-1:0]  s1_en_reg;
    logic [BIN_W-1:0]   s1_addr_reg [NUM_CH];

    logic [NUM_CH-1:0]  fwd_en_reg;
    logic [BIN_W-1:0]   fwd_addr_reg [NUM_CH];
    logic [COUNT_W-1:0] fwd_data_reg [NUM_CH];

    logic [COUNT_W-1:0] pixel_cnt_reg, pixel_cnt_next;
    logic [COUNT_W-1:0] peak_reg, peak_next, peak_upd;

    logic [PROD_W-1:0]  prod_lo_reg, prod_hi_reg;
    logic [THR_W-1:0]   thr_lo_reg, thr_hi_reg;
    logic [PROD_W:0]    rnd_lo, rnd_hi;

    logic               proc_valid_reg;
    logic [BIN_W-1:0]   proc_idx_reg;

    logic               out_valid_reg;
    logic [BIN_W-1:0]   out_rl_reg, out_rh_reg, out_gl_reg, out_gh_reg;
    logic [BIN_W-1:0]   out_bl_reg, out_bh_reg;
    logic [COUNT_W-1:0] out_peak_reg, out_total_reg;

    logic               in_acc;
    logic               load_out;
    logic               scan_start;

    logic [BIN_W-1:0]   pix_val   [NUM_CH];
    logic [COUNT_W-1:0] cur_cnt   [NUM_CH];
    logic [COUNT_W-1:0] inc_cnt   [NUM_CH];
    logic               ram_we    [NUM_CH];
    logic [BIN_W-1:0]   ram_waddr [NUM_CH];
    logic [COUNT_W-1:0] ram_wdata [NUM_CH];
    logic [BIN_W-1:0]   ram_raddr [NUM_CH];
    logic [COUNT_W-1:0] ram_rdata [NUM_CH];
    logic [BIN_W-1:0]   lo_b      [NUM_CH];
    logic [BIN_W-1:0]   hi_b      [NUM_CH];

    assign in_ready = (st_reg == ST_RUN);
    assign in_acc   = in_valid && in_ready;

    assign pix_val[0] = red_value;
    assign pix_val[1] = green_value;
    assign pix_val[2] = blue_value;

    genvar c;
    generate
        for (c = 0; c < NUM_CH; c++)
        begin : g_ch
            hpb_ram #(
                .WIDTH (COUNT_W),
                .DEPTH (BINS)
            ) u_ram (
                .clk     (clk),
                .wr_en   (ram_we[c]),
                .wr_addr (ram_waddr[c]),
                .wr_data (ram_wdata[c]),
                .rd_addr (ram_raddr[c]),
                .rd_data (ram_rdata[c])
            );

            hpb_scan u_scan (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (scan_start),
                .valid    (proc_valid_reg),
                .idx      (proc_idx_reg),
                .count    (ram_rdata[c]),
                .lo_thr   (thr_lo_reg),
                .hi_thr   (thr_hi_reg),
                .lo_bound (lo_b[c]),
                .hi_bound (hi_b[c])
            );
        end
    endgenerate

    // bin update, forwarding the write of the previous cycle
    always_comb
    begin
        peak_upd = peak_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            cur_cnt[i] = (fwd_en_reg[i] && (fwd_addr_reg[i] == s1_addr_reg[i]))
                         ? fwd_data_reg[i] : ram_rdata[i];
            inc_cnt[i] = (cur_cnt[i] < COUNT_LIMIT) ? cur_cnt[i] + COUNT_W'(1) : cur_cnt[i];
            if (s1_valid_reg && s1_en_reg[i] && (inc_cnt[i] > peak_upd))
            begin
                peak_upd = inc_cnt[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            ram_raddr[i] = (st_reg == ST_SCAN) ? cnt_reg : pix_val[i];
            if (st_reg == ST_CLEAR)
            begin
                ram_we[i]    = 1'b1;
                ram_waddr[i] = cnt_reg;
                ram_wdata[i] = '0;
            end
            else if (proc_valid_reg)
            begin
                ram_we[i]    = 1'b1;
                ram_waddr[i] = proc_idx_reg;
                ram_wdata[i] = '0;
            end
            else
            begin
                ram_we[i]    = s1_valid_reg && s1_en_reg[i];
                ram_waddr[i] = s1_addr_reg[i];
                ram_wdata[i] = inc_cnt[i];
            end
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        scan_start = 1'b0;
        case (st_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + BIN_W'(1);
                if (cnt_reg == BIN_LAST)
                begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_acc && (action == ACTION_END))
                begin
                    st_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                st_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                scan_start = 1'b1;
                cnt_next   = '0;
                st_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + BIN_W'(1);
                if (cnt_reg == BIN_LAST)
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                st_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    st_next  = ST_RUN;
                end
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pixel_cnt_next = pixel_cnt_reg;
        if (load_out)
        begin
            pixel_cnt_next = '0;
        end
        else if (in_acc && (action != ACTION_END) && (pixel_cnt_reg < COUNT_LIMIT))
        begin
            pixel_cnt_next = pixel_cnt_reg + COUNT_W'(1);
        end
        peak_next = load_out ? '0 : peak_upd;
    end

    assign rnd_lo = {1'b0, prod_lo_reg} + ROUND_HALF;
    assign rnd_hi = {1'b0, prod_hi_reg} + ROUND_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_CLEAR;
            cnt_reg        <= '0;
            gray_mode_reg  <= 1'b0;
            lower_frac_reg <= LOWER_FRACTION_RST;
            upper_frac_reg <= UPPER_FRACTION_RST;
            s1_valid_reg   <= 1'b0;
            fwd_en_reg     <= '0;
            pixel_cnt_reg  <= '0;
            peak_reg       <= '0;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            cnt_reg        <= cnt_next;
            s1_valid_reg   <= in_acc && (action != ACTION_END);
            pixel_cnt_reg  <= pixel_cnt_next;
            peak_reg       <= peak_next;
            proc_valid_reg <= (st_reg == ST_SCAN);
            for (int i = 0; i < NUM_CH; i++)
            begin
                fwd_en_reg[i] <= s1_valid_reg && s1_en_reg[i];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GRAY_MODE:      gray_mode_reg  <= cfg_data[0];
                    CFG_LOWER_FRACTION: lower_frac_reg <= cfg_data;
                    CFG_UPPER_FRACTION: upper_frac_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_en_reg <= {!gray_mode_reg, !gray_mode_reg, 1'b1};
        for (int i = 0; i < NUM_CH; i++)
        begin
            s1_addr_reg[i]  <= pix_val[i];
            fwd_addr_reg[i] <= s1_addr_reg[i];
            fwd_data_reg[i] <= inc_cnt[i];
        end
        proc_idx_reg <= cnt_reg;
        if (st_reg == ST_MULT)
        begin
            prod_lo_reg <= PROD_W'(pixel_cnt_reg) * PROD_W'(lower_frac_reg);
            prod_hi_reg <= PROD_W'(pixel_cnt_reg) * PROD_W'(upper_frac_reg);
        end
        if (st_reg == ST_ROUND)
        begin
            thr_lo_reg <= rnd_lo[PROD_W -: THR_W];
            thr_hi_reg <= rnd_hi[PROD_W -: THR_W];
        end
        if (load_out)
        begin
            out_rl_reg    <= lo_b[0];
            out_rh_reg    <= hi_b[0];
            out_gl_reg    <= gray_mode_reg ? lo_b[0] : lo_b[1];
            out_gh_reg    <= gray_mode_reg ? hi_b[0] : hi_b[1];
            out_bl_reg    <= gray_mode_reg ? lo_b[0] : lo_b[2];
            out_bh_reg    <= gray_mode_reg ? hi_b[0] : hi_b[2];
            out_peak_reg  <= peak_reg;
            out_total_reg <= pixel_cnt_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign red_low_bound    = out_rl_reg;
    assign red_high_bound   = out_rh_reg;
    assign green_low_bound  = out_gl_reg;
    assign green_high_bound = out_gh_reg;
    assign blue_low_bound   = out_bl_reg;
    assign blue_high_bound  = out_bh_reg;
    assign peak_bin_count   = out_peak_reg;
    assign total_pixels     = out_total_reg;

    `HPB_ASSERT_IMP(a_s1_from_run, s1_valid_reg, $past(st_reg) == ST_RUN)
    `HPB_ASSERT_IMP(a_no_pixel_in_scan, proc_valid_reg, !s1_valid_reg)
    `HPB_ASSERT_IMP(a_out_from_done, $rose(out_valid_reg), $past(st_reg) == ST_DONE)
    `HPB_ASSERT_IMP(a_count_limit, 1'b1, (pixel_cnt_reg <= COUNT_LIMIT) && (peak_reg <= COUNT_LIMIT))
    `HPB_ASSERT_NXT(a_clear_after_load, load_out, (pixel_cnt_reg == '0) && (peak_reg == '0))

endmodule

@@ tb/percentile_bounds_checker.sv @@
module percentile_bounds_checker
    import hpb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 action,
    input  logic [BIN_W-1:0]     red_value,
    input  logic [BIN_W-1:0]     green_value,
    input  logic [BIN_W-1:0]     blue_value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [BIN_W-1:0]     red_low_bound,
    input  logic [BIN_W-1:0]     red_high_bound,
    input  logic [BIN_W-1:0]     green_low_bound,
    input  logic [BIN_W-1:0]     green_high_bound,
    input  logic [BIN_W-1:0]     blue_low_bound,
    input  logic [BIN_W-1:0]     blue_high_bound,
    input  logic [COUNT_W-1:0]   peak_bin_count,
    input  logic [COUNT_W-1:0]   total_pixels,
    output int                   mismatch_count,
    output int                   results_pending,
    output int                   bounds_checked
);

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [BIN_W-1:0]   red_lo;
        logic [BIN_W-1:0]   red_hi;
        logic [BIN_W-1:0]   green_lo;
        logic [BIN_W-1:0]   green_hi;
        logic [BIN_W-1:0]   blue_lo;
        logic [BIN_W-1:0]   blue_hi;
        logic [COUNT_W-1:0] peak;
        logic [COUNT_W-1:0] total;
    } bound_set_t;

    logic               gray_mode;
    logic [FRAC_W-1:0]  lower_frac;
    logic [FRAC_W-1:0]  upper_frac;
    logic [COUNT_W-1:0] bin_tally [NUM_CH][BINS];
    logic [COUNT_W-1:0] pixel_tally;
    logic [COUNT_W-1:0] peak_tally;
    bound_set_t         expected_bounds [$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic clear_image();
        int ch;
        int b;
        for (ch = 0; ch < NUM_CH; ch++)
            for (b = 0; b < BINS; b++)
                bin_tally[ch][b] = '0;
        pixel_tally = '0;
        peak_tally  = '0;
    endtask

    task automatic tally_bin(input int ch, input logic [BIN_W-1:0] v);
        if (bin_tally[ch][v] < COUNT_LIMIT)
            bin_tally[ch][v] = bin_tally[ch][v] + 1'b1;
        if (bin_tally[ch][v] > peak_tally)
            peak_tally = bin_tally[ch][v];
    endtask

    // low bound: first bin whose running sum passes lo_thr; high bound: first later
    // bin where the same running sum passes hi_thr
    task automatic scan_channel(input int ch, input longint lo_thr, input longint hi_thr,
                                output logic [BIN_W-1:0] lo_bin,
                                output logic [BIN_W-1:0] hi_bin);
        longint run_sum;
        int     i;
        int     j;
        run_sum = 0;
        lo_bin  = BOUND_NONE;
        hi_bin  = BOUND_NONE;
        for (i = 0; i < BINS; i++)
        begin
            run_sum += longint'(bin_tally[ch][i]);
            if (run_sum > lo_thr)
            begin
                lo_bin = BIN_W'(i);
                break;
            end
        end
        for (j = i + 1; j < BINS; j++)
        begin
            run_sum += longint'(bin_tally[ch][j]);
            if (run_sum > hi_thr)
            begin
                hi_bin = BIN_W'(j);
                break;
            end
        end
    endtask

    task automatic predict_bounds();
        bound_set_t       want;
        longint           lo_thr;
        longint           hi_thr;
        logic [BIN_W-1:0] lo_bin;
        logic [BIN_W-1:0] hi_bin;
        lo_thr = (longint'(pixel_tally) * longint'(lower_frac) + longint'(ROUND_HALF))
                 >> FRAC_SHIFT;
        hi_thr = (longint'(pixel_tally) * longint'(upper_frac) + longint'(ROUND_HALF))
                 >> FRAC_SHIFT;
        scan_channel(CH_RED, lo_thr, hi_thr, lo_bin, hi_bin);
        want.red_lo = lo_bin;
        want.red_hi = hi_bin;
        if (gray_mode)
        begin
            want.green_lo = want.red_lo;
            want.green_hi = want.red_hi;
            want.blue_lo  = want.red_lo;
            want.blue_hi  = want.red_hi;
        end
        else
        begin
            scan_channel(CH_GREEN, lo_thr, hi_thr, lo_bin, hi_bin);
            want.green_lo = lo_bin;
            want.green_hi = hi_bin;
            scan_channel(CH_BLUE, lo_thr, hi_thr, lo_bin, hi_bin);
            want.blue_lo = lo_bin;
            want.blue_hi = hi_bin;
        end
        want.peak  = peak_tally;
        want.total = pixel_tally;
        expected_bounds.push_back(want);
        clear_image();
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("bound set %0d: %s = %0d, expected %0d",
                                      bounds_checked, name, got, want));
    endtask

    task automatic check_bounds(input bound_set_t got);
        bound_set_t want;
        if (expected_bounds.size() == 0)
        begin
            report_mismatch($sformatf("bound set %h with nothing expected", got));
            return;
        end
        want = expected_bounds.pop_front();
        bounds_checked++;
        check_field("red_low_bound",    got.red_lo,   want.red_lo);
        check_field("red_high_bound",   got.red_hi,   want.red_hi);
        check_field("green_low_bound",  got.green_lo, want.green_lo);
        check_field("green_high_bound", got.green_hi, want.green_hi);
        check_field("blue_low_bound",   got.blue_lo,  want.blue_lo);
        check_field("blue_high_bound",  got.blue_hi,  want.blue_hi);
        check_field("peak_bin_count",   got.peak,     want.peak);
        check_field("total_pixels",     got.total,    want.total);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_image();
            gray_mode  = 1'b0;
            lower_frac = LOWER_FRACTION_RST;
            upper_frac = UPPER_FRACTION_RST;
            expected_bounds.delete();
            results_pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (action == ACTION_END)
                    predict_bounds();
                else
                begin
                    if (pixel_tally < COUNT_LIMIT)
                        pixel_tally = pixel_tally + 1'b1;
                    tally_bin(CH_RED, red_value);
                    if (!gray_mode)
                    begin
                        tally_bin(CH_GREEN, green_value);
                        tally_bin(CH_BLUE, blue_value);
                    end
                end
            end
            if (out_valid && out_ready)
                check_bounds({red_low_bound, red_high_bound, green_low_bound,
                              green_high_bound, blue_low_bound, blue_high_bound,
                              peak_bin_count, total_pixels});
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GRAY_MODE:      gray_mode  = cfg_data[0];
                    CFG_LOWER_FRACTION: lower_frac = cfg_data;
                    CFG_UPPER_FRACTION: upper_frac = cfg_data;
                    default: ;
                endcase
            end
            results_pending = expected_bounds.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top
    import hpb_pkg::*;
();

    localparam int                   TARGET_ITEMS  = 1270;
    localparam int                   DRAIN_CYCLES  = 270;
    localparam logic                 ACTION_PIXEL  = ~ACTION_END;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = CFG_IDX_W'(3);

    logic               clk              = 1'b0;
    logic               rst_n            = 1'b0;
    logic               cfg_write        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_GRAY_MODE;
    logic [FRAC_W-1:0]  cfg_data         = '0;
    logic               in_valid         = 1'b0;
    logic               in_ready;
    logic               action           = 1'b0;
    logic [BIN_W-1:0]   red_value        = '0;
    logic [BIN_W-1:0]   green_value      = '0;
    logic [BIN_W-1:0]   blue_value       = '0;
    logic               out_valid;
    logic               out_ready        = 1'b0;
    logic [BIN_W-1:0]   red_low_bound;
    logic [BIN_W-1:0]   red_high_bound;
    logic [BIN_W-1:0]   green_low_bound;
    logic [BIN_W-1:0]   green_high_bound;
    logic [BIN_W-1:0]   blue_low_bound;
    logic [BIN_W-1:0]   blue_high_bound;
    logic [COUNT_W-1:0] peak_bin_count;
    logic [COUNT_W-1:0] total_pixels;

    int                 mismatch_count;
    int                 results_pending;
    int                 bounds_checked;

    int                 items_sent   = 0;
    int                 pixels_sent  = 0;
    int                 images_sent  = 0;
    int                 phases_run   = 0;
    int                 burst_left   = 0;
    int unsigned        stall_tick   = 0;
    logic               gray_now     = 1'b0;

    histogram_percentile_bounds_core u_dut (.*);

    percentile_bounds_checker u_bounds_check (.*);

    always #5 clk = ~clk;

    // receiver: free-flowing, random, long stalls, mostly-ready, in turn
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (stall_tick[3:0] == 4'd0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_item(input logic act, input logic [BIN_W-1:0] r,
                             input logic [BIN_W-1:0] g, input logic [BIN_W-1:0] b);
        in_valid    <= 1'b1;
        action      <= act;
        red_value   <= r;
        green_value <= g;
        blue_value  <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        if (act == ACTION_END)
            images_sent++;
        else
            pixels_sent++;
    endtask

    task automatic pace();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAC_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // hold off input until every bound set is back and the scan has wound down
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BIN_W-1:0] pick_value(input int shape,
                                                    input logic [BIN_W-1:0] centre);
        case (shape)
            0: return BIN_W'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) != 0) ? BIN_LAST : '0;
            2: return centre + BIN_W'($urandom_range(0, 6)) - BIN_W'(3);
            3: return centre;
            default: return ($urandom_range(0, 3) == 0) ? centre : ~centre;
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FRAC_W'(65536);
            2: return '1;
            3: return LOWER_FRACTION_RST;
            4: return UPPER_FRACTION_RST;
            5: return FRAC_W'(32768);
            6: return FRAC_W'(65535);
            default: return FRAC_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int pick_image_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(100, 220);
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    task automatic send_image(input int n_pixels, input bit flip_mode);
        int               shape;
        int               k;
        logic [BIN_W-1:0] cr;
        logic [BIN_W-1:0] cg;
        logic [BIN_W-1:0] cb;
        shape = $urandom_range(0, 4);
        cr    = BIN_W'($urandom);
        cg    = BIN_W'($urandom);
        cb    = BIN_W'($urandom);
        for (k = 0; k < n_pixels; k++)
        begin
            if (flip_mode && k == n_pixels / 2)
            begin
                settle();
                gray_now = ~gray_now;
                write_reg(CFG_GRAY_MODE, FRAC_W'(gray_now));
            end
            send_item(ACTION_PIXEL, pick_value(shape, cr), pick_value(shape, cg),
                      pick_value(shape, cb));
            pace();
        end
        send_item(ACTION_END, BIN_W'($urandom), BIN_W'($urandom), BIN_W'($urandom));
        pace();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty image, then extremes, at reset settings
        send_item(ACTION_END, BIN_LAST, '0, BIN_LAST);
        send_item(ACTION_PIXEL, '0, BIN_LAST, '0);
        send_item(ACTION_PIXEL, BIN_LAST, '0, BIN_LAST);
        send_item(ACTION_PIXEL, '0, '0, '0);
        send_item(ACTION_PIXEL, BIN_LAST, BIN_LAST, BIN_LAST);
        send_item(ACTION_END, '0, '0, '0);
        settle();

        // low bound in the last bin leaves no room for a high bound
        write_reg(CFG_LOWER_FRACTION, '0);
        write_reg(CFG_UPPER_FRACTION, FRAC_W'(65536));
        repeat (3) send_item(ACTION_PIXEL, BIN_LAST, BIN_LAST, BIN_LAST);
        send_item(ACTION_END, BIN_LAST, BIN_LAST, BIN_LAST);
        settle();

        // gray, threshold above pixel count, write to an unused index
        gray_now = 1'b1;
        write_reg(CFG_GRAY_MODE, FRAC_W'(gray_now));
        write_reg(CFG_LOWER_FRACTION, '1);
        write_reg(CFG_UPPER_FRACTION, '0);
        write_reg(CFG_UNUSED, '1);
        send_item(ACTION_PIXEL, 8'd17, 8'd200, 8'd5);
        send_item(ACTION_PIXEL, 8'd200, 8'd17, 8'd5);
        send_item(ACTION_PIXEL, 8'd17, 8'd5, 8'd200);
        send_item(ACTION_END, '0, '0, '0);
        settle();

        // mode switched inside an image
        write_reg(CFG_LOWER_FRACTION, FRAC_W'(32768));
        write_reg(CFG_UPPER_FRACTION, FRAC_W'(32768));
        send_item(ACTION_PIXEL, '0, 8'd9, 8'd9);
        send_item(ACTION_PIXEL, BIN_LAST, 8'd9, 8'd9);
        settle();
        gray_now = 1'b0;
        write_reg(CFG_GRAY_MODE, FRAC_W'(gray_now));
        send_item(ACTION_PIXEL, 8'd128, '0, BIN_LAST);
        send_item(ACTION_PIXEL, 8'd127, BIN_LAST, '0);
        send_item(ACTION_END, '0, '0, '0);

        while (items_sent < TARGET_ITEMS)
        begin
            settle();
            phases_run++;
            gray_now = 1'($urandom_range(0, 1));
            write_reg(CFG_GRAY_MODE, FRAC_W'(gray_now));
            write_reg(CFG_LOWER_FRACTION, ($urandom_range(0, 1) != 0) ? pick_fraction()
                                          : FRAC_W'($urandom_range(0, 8192)));
            write_reg(CFG_UPPER_FRACTION, pick_fraction());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, FRAC_W'($urandom));
            repeat ($urandom_range(1, 4))
                send_image(pick_image_size(), $urandom_range(0, 7) == 0);
        end

        settle();
        $display("Run: %0d items (%0d pixels, %0d images) over %0d random settings",
                 items_sent, pixels_sent, images_sent, phases_run);
        $display("Bound sets compared: %0d, mismatches: %0d", bounds_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d bound sets outstanding", results_pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
